// File: rtl/core/quadtree_buddy_allocator_macros.svh
// ---------------------------------------------------------------------------
// Quadtree buddy allocator assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef QUADTREE_BUDDY_ALLOCATOR_MACROS_SVH
`define QUADTREE_BUDDY_ALLOCATOR_MACROS_SVH

// Property checked every clock, disabled while reset is asserted
`define QBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define QBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/qba_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quadtree buddy allocator package
// Item types, node state codes, sequencer states and shared constants.
// ---------------------------------------------------------------------------
package qba_pkg;

    // Default configuration of the tree and the atlas
    localparam int MAX_LEVELS_DEF     = 6;
    localparam int MAX_ATLAS_LOG2_DEF = 13;

    // Fixed field widths
    localparam int SZW       = 4;
    localparam int POSW      = 13;
    // Node number width for the deepest supported tree (eight levels)
    localparam int NODEW_MAX = 15;

    localparam logic [SZW-1:0] ATLAS_RST = 4'd12;

    // Node state codes; the unused code reads as allocated
    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_SPLIT = 2'd1,
        ST_ALLOC = 2'd2
    } t_node_st;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_CLEAR = 1'b1
    } t_req_type;

    typedef struct packed {
        logic           req_type;
        logic [SZW-1:0] request_size_log2;
    } t_in_item;

    typedef struct packed {
        logic            granted;
        logic [POSW-1:0] pos_x;
        logic [POSW-1:0] pos_y;
        logic [SZW-1:0]  tile_size_log2;
    } t_out_item;

    // Walk sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EVAL,
        S_SPLIT,
        S_NEXT,
        S_DONE
    } t_walk_state;

    // Node store access for one cycle
    typedef struct packed {
        logic                 rd_en;
        logic [NODEW_MAX-1:0] rd_node;
        logic                 wr_en;
        logic [NODEW_MAX-1:0] wr_node;
        t_node_st             wr_st;
        logic                 root_clr;
    } t_store_cmd;

endpackage

// File: rtl/core/qba_node_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quadtree node state store
// Root state in a reset register, all other nodes in a one-port memory
// with a registered read.
// ---------------------------------------------------------------------------
module qba_node_store #(
    parameter int NODE_COUNT = 1365,
    parameter int NW         = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qba_pkg::t_store_cmd i_cmd,
    output qba_pkg::t_node_st  o_rd_st
);
    import qba_pkg::*;

    localparam int AIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    logic [1:0] r_mem [0:NODE_COUNT-1];
    t_node_st   r_root;
    logic [1:0] r_rd;

    logic rd_root;
    logic wr_root;

    assign rd_root = (i_cmd.rd_node[NW-1:0] == '0);
    assign wr_root = (i_cmd.wr_node[NW-1:0] == '0);

    // Root: free after reset, after a clear and after a size write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= ST_FREE;
        end else if (i_cmd.root_clr) begin
            r_root <= ST_FREE;
        end else if (i_cmd.wr_en && wr_root) begin
            r_root <= i_cmd.wr_st;
        end
    end

    // Node memory, one access per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && !wr_root) begin
            r_mem[i_cmd.wr_node[AIW-1:0]] <= i_cmd.wr_st;
        end
        if (i_cmd.rd_en) begin
            r_rd <= rd_root ? r_root : r_mem[i_cmd.rd_node[AIW-1:0]];
        end
    end

    assign o_rd_st = t_node_st'(r_rd);

endmodule

// File: rtl/core/qba_walk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quadtree walk sequencer
// Depth-first search over the node store: descend, split, step to the next
// sibling or climb, one node operation per cycle.
// ---------------------------------------------------------------------------
module qba_walk #(
    parameter int MAX_LEVELS     = 6,
    parameter int MAX_ATLAS_LOG2 = 13
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  qba_pkg::t_in_item         i_in,
    input  logic [qba_pkg::SZW-1:0]   i_atlas,
    output qba_pkg::t_store_cmd       o_cmd,
    input  qba_pkg::t_node_st         i_rd_st,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output qba_pkg::t_out_item        o_res
);
    import qba_pkg::*;

    `include "quadtree_buddy_allocator_macros.svh"

    localparam int NODE_COUNT = ((1 << (2 * MAX_LEVELS)) - 1) / 3;
    localparam int NW = (NODE_COUNT > 4) ? $clog2(NODE_COUNT) : 3;
    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int AW = MAX_ATLAS_LOG2;

    t_walk_state     r_state, n_state;
    logic [NW-1:0]   r_node, n_node;
    logic [LW-1:0]   r_level, n_level;
    logic [SZW-1:0]  r_sz, n_sz;
    logic [SZW-1:0]  r_req, n_req;
    logic [AW-1:0]   r_x, n_x;
    logic [AW-1:0]   r_y, n_y;
    logic            r_kfree, n_kfree;
    logic [1:0]      r_scnt, n_scnt;
    t_out_item       r_res, n_res;

    logic [SZW-1:0]  atlas_eff;
    logic            accept;
    logic            range_bad;
    t_node_st        cur_st;
    logic            can_descend;
    logic            split_down;
    logic            free_hit;
    logic            free_split;
    logic [NW+1:0]   child_base;
    logic [NW+1:0]   child_wr;
    logic [NW-1:0]   node_m1;
    logic [1:0]      sib_idx;
    logic [AW-1:0]   sz_bit;

    // Clamp the configured atlas size
    assign atlas_eff = (i_atlas > SZW'(AW)) ? SZW'(AW) : i_atlas;
    assign accept    = i_in_valid && !o_in_stall;
    assign range_bad = (i_in.request_size_log2 > atlas_eff) ||
                       ((atlas_eff - i_in.request_size_log2) > SZW'(MAX_LEVELS - 1));

    // Node evaluation terms
    assign cur_st      = r_kfree ? ST_FREE : i_rd_st;
    assign can_descend = (r_level < LW'(MAX_LEVELS - 1));
    assign split_down  = (cur_st == ST_SPLIT) && (r_sz > r_req) && can_descend;
    assign free_hit    = (cur_st == ST_FREE) && (r_sz == r_req);
    assign free_split  = (cur_st == ST_FREE) && (r_sz > r_req) && can_descend;

    // Child and sibling arithmetic: children of n are 4n+1 .. 4n+4
    assign child_base = {r_node, 2'b00} + (NW+2)'(1);
    assign child_wr   = child_base + (NW+2)'(r_scnt) + (NW+2)'(1);
    assign node_m1    = r_node - NW'(1);
    assign sib_idx    = node_m1[1:0];
    assign sz_bit     = AW'(1) << r_sz;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.req_type == REQ_CLEAR || range_bad) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: n_state = S_EVAL;
            S_EVAL: begin
                if (split_down) begin
                    n_state = S_LOOK;
                end else if (free_hit) begin
                    n_state = S_DONE;
                end else if (free_split) begin
                    n_state = S_SPLIT;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_SPLIT: begin
                if (r_scnt == 2'd2) begin
                    n_state = S_EVAL;
                end
            end
            S_NEXT: begin
                if (r_level == '0) begin
                    n_state = S_DONE;
                end else if (sib_idx != 2'd3) begin
                    n_state = S_LOOK;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and store commands
    always_comb begin
        n_node  = r_node;
        n_level = r_level;
        n_sz    = r_sz;
        n_req   = r_req;
        n_x     = r_x;
        n_y     = r_y;
        n_kfree = 1'b0;
        n_scnt  = r_scnt;
        n_res   = r_res;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_node  = '0;
                    n_level = '0;
                    n_sz    = atlas_eff;
                    n_req   = i_in.request_size_log2;
                    n_x     = '0;
                    n_y     = '0;
                    n_res   = '0;
                    o_cmd.root_clr = (i_in.req_type == REQ_CLEAR);
                end
            end
            S_LOOK: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_node = NODEW_MAX'(r_node);
            end
            S_EVAL: begin
                if (split_down) begin
                    n_node  = child_base[NW-1:0];
                    n_level = r_level + LW'(1);
                    n_sz    = r_sz - SZW'(1);
                end else if (free_hit) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_node = NODEW_MAX'(r_node);
                    o_cmd.wr_st   = ST_ALLOC;
                    n_res.granted        = 1'b1;
                    n_res.pos_x          = POSW'(r_x);
                    n_res.pos_y          = POSW'(r_y);
                    n_res.tile_size_log2 = r_sz;
                end else if (free_split) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_node = NODEW_MAX'(r_node);
                    o_cmd.wr_st   = ST_SPLIT;
                    n_scnt        = 2'd0;
                end
            end
            S_SPLIT: begin
                // Children 1..3 become free; child 0 is entered as free next
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_node = NODEW_MAX'(child_wr[NW-1:0]);
                o_cmd.wr_st   = ST_FREE;
                n_scnt        = r_scnt + 2'd1;
                if (r_scnt == 2'd2) begin
                    n_node  = child_base[NW-1:0];
                    n_level = r_level + LW'(1);
                    n_sz    = r_sz - SZW'(1);
                    n_kfree = 1'b1;
                end
            end
            S_NEXT: begin
                if (r_level == '0) begin
                    n_res = '0;
                end else begin
                    case (sib_idx)
                        2'd0: begin
                            n_node = r_node + NW'(1);
                            n_x    = r_x | sz_bit;
                        end
                        2'd1: begin
                            n_node = r_node + NW'(1);
                            n_x    = r_x & ~sz_bit;
                            n_y    = r_y | sz_bit;
                        end
                        2'd2: begin
                            n_node = r_node + NW'(1);
                            n_x    = r_x | sz_bit;
                        end
                        default: begin
                            // Last child done: climb to the parent
                            n_node  = NW'(node_m1 >> 2);
                            n_level = r_level - LW'(1);
                            n_sz    = r_sz + SZW'(1);
                            n_x     = r_x & ~sz_bit;
                            n_y     = r_y & ~sz_bit;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kfree <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kfree <= n_kfree;
        end
        r_node  <= n_node;
        r_level <= n_level;
        r_sz    <= n_sz;
        r_req   <= n_req;
        r_x     <= n_x;
        r_y     <= n_y;
        r_scnt  <= n_scnt;
        r_res   <= n_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    `QBA_ASSERT(a_grant_size, i_clk, i_rst_n, o_res_valid && o_res.granted |-> o_res.tile_size_log2 == r_req, "granted tile size differs from request")
    `QBA_ASSERT(a_fail_zero, i_clk, i_rst_n, o_res_valid && !o_res.granted |-> (o_res.pos_x == '0 && o_res.pos_y == '0 && o_res.tile_size_log2 == '0), "failed result carries nonzero fields")
    `QBA_ASSERT(a_kfree_eval, i_clk, i_rst_n, r_kfree |-> r_state == S_EVAL, "known-free flag outside node evaluation")
    `QBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE, "sequencer idle after taking an item")

endmodule

// File: rtl/core/quadtree_buddy_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quadtree buddy allocator
// Square 2D buddy allocator for a texture atlas held as a quadtree of node
// states; returns the corner and size of each allocated tile.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall, i_in_item): one request item,
//   allocate a 2^n tile or clear the atlas. Items are taken one at a time;
//   o_in_stall is high from acceptance until the result is handed to the
//   output register, and also while a config write is offered.
//   Output channel (o_out_valid / i_out_stall, o_out_item): one result per
//   item. A registered output stage holds it while the receiver stalls; a
//   new item may be taken while that result still waits, but its result
//   then holds in the walker and the input stays stalled.
//   Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data): atlas edge as
//   log2; each write also frees the whole atlas. Ready only when idle.
// Sequencing (acceptance to o_out_valid):
//   Clear and out-of-range requests go straight to the result without a
//   walk. Allocate reads each visited node from the store, steps to a
//   sibling or climbs for a node that fails, and writes the child states
//   of a fresh split, one node access at a time on the single-port node
//   store.
// Reset: root node free, atlas size 12; memory needs no clearing pass.
// ---------------------------------------------------------------------------
module quadtree_buddy_allocator #(
    parameter int MAX_LEVELS     = qba_pkg::MAX_LEVELS_DEF,
    parameter int MAX_ATLAS_LOG2 = qba_pkg::MAX_ATLAS_LOG2_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  qba_pkg::t_in_item       i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output qba_pkg::t_out_item      o_out_item,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [qba_pkg::SZW-1:0] i_cfg_data
);
    import qba_pkg::*;

    localparam int NODE_COUNT = ((1 << (2 * MAX_LEVELS)) - 1) / 3;
    localparam int NW = (NODE_COUNT > 4) ? $clog2(NODE_COUNT) : 3;

    logic [SZW-1:0] r_atlas;
    logic           r_ovld;
    t_out_item      r_out;

    logic           cfg_we;
    logic           walk_in_valid;
    logic           walk_stall;
    t_store_cmd     walk_cmd;
    t_store_cmd     store_cmd;
    t_node_st       rd_st;
    logic           res_valid;
    logic           res_ready;
    t_out_item      res;

    // An offered config write holds off new items so the two never coincide
    assign walk_in_valid = i_in_valid && !i_cfg_valid;
    assign o_in_stall    = walk_stall || i_cfg_valid;

    // Config register: write only while the walker is idle
    assign o_cfg_ready = !walk_stall;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas <= ATLAS_RST;
        end else if (cfg_we) begin
            r_atlas <= i_cfg_data;
        end
    end

    // A size write frees the root as well
    always_comb begin
        store_cmd          = walk_cmd;
        store_cmd.root_clr = walk_cmd.root_clr | cfg_we;
    end

    qba_walk #(
        .MAX_LEVELS     (MAX_LEVELS),
        .MAX_ATLAS_LOG2 (MAX_ATLAS_LOG2)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (walk_in_valid),
        .o_in_stall  (walk_stall),
        .i_in        (i_in_item),
        .i_atlas     (r_atlas),
        .o_cmd       (walk_cmd),
        .i_rd_st     (rd_st),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    qba_node_store #(
        .NODE_COUNT (NODE_COUNT),
        .NW         (NW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (store_cmd),
        .o_rd_st (rd_st)
    );

    // Output register
    assign res_ready = !r_ovld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovld <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovld <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_item  = r_out;

endmodule
